/* rtl/lzwvc_pkg.sv */
// Shared types and fixed constants of the LZW variable-width compressor.
// No dependencies.
package lzwvc_pkg;

   localparam int CODE_BITS  = 12;  // dictionary code and prefix width
   localparam int NFC_BITS   = 13;  // next free code counter width
   localparam int WIDTH_BITS = 4;   // code width register
   localparam int BYTE_BITS  = 8;
   localparam int OUT_BITS   = 32;  // packed_word port width
   localparam int MAX_WIDTH  = 12;  // widest code

   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_STOP = 1'b1;

   // Packer status for one code
   typedef struct packed {
      logic emit;     // a word is completed by this code
      logic last;     // that word closes the stream
      logic second;   // a tail word is still left in the buffer for flush
   } pack_ctl_type;

endpackage

/* rtl/lzwvc_chan_if.sv */
// Valid/ready channel interfaces for the request and response items.
// Depends on lzwvc_pkg.
interface lzwvc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [lzwvc_pkg::BYTE_BITS-1:0] data_byte;
   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface lzwvc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lzwvc_pkg::OUT_BITS-1:0] packed_word;
   logic                          last_word;
   modport source (output valid, output packed_word, output last_word, input ready);
   modport sink   (input valid, input packed_word, input last_word, output ready);
endinterface

/* rtl/lzw_variable_width_compressor.sv */
// LZW compressor, variable code width, codes packed MSB-first into words.
// Sequence: a data byte with a pending prefix scans the live dictionary entries (one read
// a cycle), then on a miss emits the prefix code, waiting while the output register is full.
// A stop item emits any pending prefix, the end code and any tail word, waiting likewise.
// Throughput: one item at a time; ready is high only between items.
// Reset (synchronous, active high) clears control state; dictionary RAM is
// left as is, since only entries written in the current stream are read.
module lzw_variable_width_compressor #(
   parameter int SYMBOL_COUNT = 256,
   parameter int INIT_WIDTH   = 9,
   parameter int WORD_BITS    = 32,
   parameter int DICT_DEPTH   = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   lzwvc_req_if.sink                         req_chan,
   lzwvc_rsp_if.source                       rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [lzwvc_pkg::CODE_BITS-1:0]   csr_wr_data
);

   localparam int CB = lzwvc_pkg::CODE_BITS;
   localparam int NB = lzwvc_pkg::NFC_BITS;
   localparam int WB = lzwvc_pkg::WIDTH_BITS;
   localparam int BB = lzwvc_pkg::BYTE_BITS;
   localparam int FW = $clog2(WORD_BITS + 1);
   localparam int AW = $clog2(DICT_DEPTH);
   localparam logic [NB-1:0] FIRST_CODE = NB'(SYMBOL_COUNT + 1);
   localparam logic [CB-1:0] END_CODE   = CB'(SYMBOL_COUNT);
   localparam logic [CB-1:0] INIT_WMAX  = CB'((1 << INIT_WIDTH) - 1);
   localparam logic [CB-1:0] LIMIT_RST  = CB'(4095);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_MISS, ST_TAIL, ST_STOP_PFX, ST_STOP_EOD, ST_FLUSH2
   } state_type;

   state_type state_ff, state_in;
   logic [BB-1:0]        byte_ff, byte_in;
   logic [CB-1:0]        prefix_ff, prefix_in;
   logic                 pending_ff, pending_in;
   logic [NB-1:0]        nfc_ff, nfc_in;
   logic [WB-1:0]        width_ff, width_in;
   logic [CB-1:0]        wmax_ff, wmax_in;
   logic [WORD_BITS-1:0] buf_ff, buf_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [CB-1:0]        limit_ff;
   logic [NB-1:0]        k_ff, k_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [CB-1:0]        cmp_code_ff, cmp_code_in;
   logic                 out_valid_ff, out_valid_in;
   logic [lzwvc_pkg::OUT_BITS-1:0] out_word_ff, out_word_in;
   logic                 out_last_ff, out_last_in;

   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [CB+BB-1:0]     rd_data, wr_data;
   logic                 match, out_free;
   logic [BB-1:0]        clamped;

   logic [CB-1:0]        pk_code;
   logic                 pk_flush;
   lzwvc_pkg::pack_ctl_type pk_ctl;
   logic [WORD_BITS-1:0] pk_word, pk_buf;
   logic [FW-1:0]        pk_fill;
   logic [WORD_BITS+lzwvc_pkg::OUT_BITS-1:0] wide_word;

   logic [NB-1:0]        t_nfc;
   logic [WB-1:0]        t_width;
   logic [CB-1:0]        t_wmax;

   // Dictionary: {prefix code, byte} per code
   lzwvc_ram #(.WIDTH(CB + BB), .DEPTH(DICT_DEPTH)) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzwvc_packer #(.WORD_BITS(WORD_BITS)) u_pack (
      .code     (pk_code),
      .width    (width_ff),
      .flush    (pk_flush),
      .buf_cur  (buf_ff),
      .fill_cur (fill_ff),
      .ctl      (pk_ctl),
      .word_out (pk_word),
      .buf_nxt  (pk_buf),
      .fill_nxt (pk_fill)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.packed_word = out_word_ff;
   assign rsp_chan.last_word   = out_last_ff;

   assign match    = cmp_valid_ff && (rd_data == {prefix_ff, byte_ff});
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign clamped  = ({1'b0, req_chan.data_byte} >= (BB+1)'(SYMBOL_COUNT))
                     ? BB'(SYMBOL_COUNT - 1) : req_chan.data_byte;
   assign pk_code  = (state_ff == ST_STOP_EOD) ? END_CODE : prefix_ff;
   assign pk_flush = (state_ff == ST_STOP_EOD);
   assign rd_addr  = AW'(k_ff);
   assign wr_addr  = AW'(nfc_ff);
   assign wr_data  = {prefix_ff, byte_ff};

   // Restart and width growth after a data item
   always_comb begin
      t_nfc   = nfc_ff;
      t_width = width_ff;
      t_wmax  = wmax_ff;
      if (nfc_ff > {1'b0, limit_ff}) begin
         t_nfc   = FIRST_CODE;
         t_width = WB'(INIT_WIDTH);
         t_wmax  = INIT_WMAX;
      end
      if ((t_nfc - NB'(1)) > {1'b0, t_wmax} && t_nfc != {1'b0, limit_ff}
          && t_width < WB'(lzwvc_pkg::MAX_WIDTH)) begin
         t_width = t_width + WB'(1);
         t_wmax  = {t_wmax[CB-2:0], 1'b1};
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      prefix_in    = prefix_ff;
      pending_in   = pending_ff;
      nfc_in       = nfc_ff;
      width_in     = width_ff;
      wmax_in      = wmax_ff;
      buf_in       = buf_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_code_in  = cmp_code_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wide_word    = {{lzwvc_pkg::OUT_BITS{1'b0}}, pk_word};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.mode == lzwvc_pkg::MODE_STOP) begin
                  state_in = pending_ff ? ST_STOP_PFX : ST_STOP_EOD;
               end else begin
                  byte_in = clamped;
                  if (!pending_ff) begin
                     prefix_in  = CB'(clamped);
                     pending_in = 1'b1;
                     state_in   = ST_TAIL;
                  end else begin
                     k_in         = FIRST_CODE;
                     cmp_valid_in = 1'b0;
                     state_in     = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // one read issued and one compare done per cycle
            if (match) begin
               prefix_in    = cmp_code_ff;
               cmp_valid_in = 1'b0;
               state_in     = ST_TAIL;
            end else if (k_ff < nfc_ff && 32'(k_ff) < DICT_DEPTH) begin
               rd_en        = 1'b1;
               k_in         = k_ff + NB'(1);
               cmp_valid_in = 1'b1;
               cmp_code_in  = CB'(k_ff);
            end else begin
               cmp_valid_in = 1'b0;
               state_in     = ST_MISS;
            end
         end
         ST_MISS: begin
            if (out_free) begin
               buf_in  = pk_buf;
               fill_in = pk_fill;
               if (pk_ctl.emit) begin
                  out_valid_in = 1'b1;
                  out_word_in  = wide_word[lzwvc_pkg::OUT_BITS-1:0];
                  out_last_in  = 1'b0;
               end
               wr_en     = (32'(nfc_ff) < DICT_DEPTH);
               nfc_in    = nfc_ff + NB'(1);
               prefix_in = CB'(byte_ff);
               state_in  = ST_TAIL;
            end
         end
         ST_TAIL: begin
            nfc_in   = t_nfc;
            width_in = t_width;
            wmax_in  = t_wmax;
            state_in = ST_IDLE;
         end
         ST_STOP_PFX: begin
            if (out_free) begin
               buf_in  = pk_buf;
               fill_in = pk_fill;
               if (pk_ctl.emit) begin
                  out_valid_in = 1'b1;
                  out_word_in  = wide_word[lzwvc_pkg::OUT_BITS-1:0];
                  out_last_in  = 1'b0;
               end
               state_in = ST_STOP_EOD;
            end
         end
         ST_STOP_EOD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_word_in  = wide_word[lzwvc_pkg::OUT_BITS-1:0];
               out_last_in  = pk_ctl.last;
               if (pk_ctl.second) begin
                  buf_in   = pk_buf;
                  fill_in  = pk_fill;
                  state_in = ST_FLUSH2;
               end else begin
                  buf_in     = '0;
                  fill_in    = '0;
                  prefix_in  = '0;
                  pending_in = 1'b0;
                  nfc_in     = FIRST_CODE;
                  width_in   = WB'(INIT_WIDTH);
                  wmax_in    = INIT_WMAX;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_FLUSH2: begin
            if (out_free) begin
               wide_word    = {{lzwvc_pkg::OUT_BITS{1'b0}}, buf_ff};
               out_valid_in = 1'b1;
               out_word_in  = wide_word[lzwvc_pkg::OUT_BITS-1:0];
               out_last_in  = 1'b1;
               buf_in       = '0;
               fill_in      = '0;
               prefix_in    = '0;
               pending_in   = 1'b0;
               nfc_in       = FIRST_CODE;
               width_in     = WB'(INIT_WIDTH);
               wmax_in      = INIT_WMAX;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prefix_ff    <= '0;
         pending_ff   <= 1'b0;
         nfc_ff       <= FIRST_CODE;
         width_ff     <= WB'(INIT_WIDTH);
         wmax_ff      <= INIT_WMAX;
         buf_ff       <= '0;
         fill_ff      <= '0;
         limit_ff     <= LIMIT_RST;
         cmp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         pending_ff   <= pending_in;
         nfc_ff       <= nfc_in;
         width_ff     <= width_in;
         wmax_ff      <= wmax_in;
         buf_ff       <= buf_in;
         fill_ff      <= fill_in;
         cmp_valid_ff <= cmp_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
      byte_ff     <= byte_in;
      k_ff        <= k_in;
      cmp_code_ff <= cmp_code_in;
      out_word_ff <= out_word_in;
      out_last_ff <= out_last_in;
   end

endmodule

/* rtl/lzwvc_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lzwvc_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/lzwvc_packer.sv */
// Combinational MSB-first code packer: appends one code to the word buffer.
// Depends on lzwvc_pkg.
module lzwvc_packer #(
   parameter int WORD_BITS = 32
) (
   input  logic [lzwvc_pkg::CODE_BITS-1:0]  code,
   input  logic [lzwvc_pkg::WIDTH_BITS-1:0] width,
   input  logic                             flush,
   input  logic [WORD_BITS-1:0]             buf_cur,
   input  logic [$clog2(WORD_BITS+1)-1:0]   fill_cur,
   output lzwvc_pkg::pack_ctl_type          ctl,
   output logic [WORD_BITS-1:0]             word_out,
   output logic [WORD_BITS-1:0]             buf_nxt,
   output logic [$clog2(WORD_BITS+1)-1:0]   fill_nxt
);

   localparam int FW = $clog2(WORD_BITS + 1);

   logic [lzwvc_pkg::CODE_BITS-1:0] mask;
   logic [WORD_BITS-1:0]            c;
   logic [FW:0]                     sum;
   logic [FW:0]                     excess;
   logic [WORD_BITS-1:0]            merged;

   always_comb begin
      mask   = lzwvc_pkg::CODE_BITS'((13'(1) << width) - 13'(1));
      c      = WORD_BITS'(code & mask);
      sum    = (FW+1)'(fill_cur) + (FW+1)'(width);
      excess = sum - (FW+1)'(WORD_BITS);
      ctl      = '0;
      word_out = '0;
      buf_nxt  = buf_cur;
      fill_nxt = fill_cur;
      merged   = '0;
      if (sum <= (FW+1)'(WORD_BITS)) begin
         // code fits in the current word
         merged = buf_cur | (c << ((FW+1)'(WORD_BITS) - sum));
         if (sum == (FW+1)'(WORD_BITS) || flush) begin
            ctl.emit = 1'b1;
            ctl.last = flush;
            word_out = merged;
            buf_nxt  = '0;
            fill_nxt = '0;
         end else begin
            buf_nxt  = merged;
            fill_nxt = FW'(sum);
         end
      end else begin
         // code straddles two words
         ctl.emit   = 1'b1;
         word_out   = buf_cur | (c >> excess);
         buf_nxt    = c << ((FW+1)'(WORD_BITS) - excess);
         fill_nxt   = FW'(excess);
         ctl.second = flush;
      end
   end

endmodule
